[hw/rtl/omwq_pkg.sv]
// ----------------------------------------------------------------------------
// omwq_pkg
// Shared types and constants of the owned mutex with waiter queue: command
// and status codes, thread id and queue widths.
// ----------------------------------------------------------------------------
`default_nettype none

package omwq_pkg;

  // Field widths of the command and result beats
  localparam int unsigned CmdW    = 3;
  localparam int unsigned TidW    = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 5;

  // Waiter queue: one slot per thread id, pointers wrap on their own width
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = $clog2(QueueDepth);

  typedef logic [TidW-1:0]   tid_t;
  typedef logic [PtrW-1:0]   ptr_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [CmdW-1:0] {
    CMD_LOCK     = 3'd0,
    CMD_TRYLOCK  = 3'd1,
    CMD_UNLOCK   = 3'd2,
    CMD_DESTROY  = 3'd3,
    CMD_INIT     = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_DEADLOCK   = 3'd2,
    ST_BUSY       = 3'd3,
    ST_NOT_OWNER  = 3'd4,
    ST_QUEUE_FULL = 3'd5
  } status_e;

  localparam count_t QueueFull = count_t'(QueueDepth);

endpackage

`default_nettype wire

[hw/rtl/owned_mutex_with_waiter_queue.sv]
// ----------------------------------------------------------------------------
// owned_mutex_with_waiter_queue
// Mutex with an owner and a FIFO of waiting threads. Handles lock, trylock,
// unlock with direct handoff to the head waiter, destroy check and init.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  command | in        | in_valid_i/in_ready_o  | cmd_i, thread_id_i
//  result  | out       | out_valid_o/out_ready_i| status_o, wake_valid_o,
//          |           |                        | wake_thread_o, held_o,
//          |           |                        | holder_o, waiter_count_o
//
// One beat per cycle sustained while the result is drained. A command beat
// is captured in the input register; as it advances, the mutex state is
// updated and the result register loaded in the same edge. Reset clears the
// mutex and the queue pointers; queue slots are not cleared and are read only
// once written. A stalled result holds the input register and in_ready_o low.
// ----------------------------------------------------------------------------
`default_nettype none

module owned_mutex_with_waiter_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command channel
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [omwq_pkg::CmdW-1:0]     cmd_i,
  input  wire logic [omwq_pkg::TidW-1:0]     thread_id_i,
  // result channel
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [omwq_pkg::StatusW-1:0]  status_o,
  output      logic                          wake_valid_o,
  output      logic [omwq_pkg::TidW-1:0]     wake_thread_o,
  output      logic                          held_o,
  output      logic [omwq_pkg::TidW-1:0]     holder_o,
  output      logic [omwq_pkg::CountW-1:0]   waiter_count_o
);

  // Input register
  logic                      in_vld_q;
  logic [omwq_pkg::CmdW-1:0] cmd_q;
  omwq_pkg::tid_t            tid_q;
  logic                      advance;

  // Mutex state
  logic                 locked_q, locked_d;
  omwq_pkg::tid_t       owner_q, owner_d;
  omwq_pkg::ptr_t       head_q, head_d;
  omwq_pkg::ptr_t       tail_q, tail_d;
  omwq_pkg::count_t     count_q, count_d;
  omwq_pkg::tid_t       wait_mem [omwq_pkg::QueueDepth];
  logic                 push;

  // Result register
  logic                      out_vld_q;
  omwq_pkg::status_e         status_d, status_q;
  logic                      wake_d, wake_q;
  omwq_pkg::tid_t            wake_tid_d, wake_tid_q;
  logic                      held_q;
  omwq_pkg::tid_t            holder_q;
  omwq_pkg::count_t          count_out_q;

  // Move the held beat on when the result slot is free or being drained
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Capture the command beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= cmd_i;
      tid_q <= thread_id_i;
    end
  end

  // Decode the command against the current mutex state
  always_comb begin
    locked_d   = locked_q;
    owner_d    = owner_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    push       = 1'b0;
    status_d   = omwq_pkg::ST_OK;
    wake_d     = 1'b0;
    wake_tid_d = '0;
    unique case (omwq_pkg::cmd_e'(cmd_q))
      omwq_pkg::CMD_LOCK: begin
        if (!locked_q) begin
          locked_d = 1'b1;
          owner_d  = tid_q;
        end else if (owner_q == tid_q) begin
          status_d = omwq_pkg::ST_DEADLOCK;
        end else if (count_q >= omwq_pkg::QueueFull) begin
          status_d = omwq_pkg::ST_QUEUE_FULL;
        end else begin
          push     = 1'b1;
          tail_d   = tail_q + omwq_pkg::ptr_t'(1);
          count_d  = count_q + omwq_pkg::count_t'(1);
          status_d = omwq_pkg::ST_QUEUED;
        end
      end
      omwq_pkg::CMD_TRYLOCK: begin
        if (!locked_q) begin
          locked_d = 1'b1;
          owner_d  = tid_q;
        end else begin
          status_d = omwq_pkg::ST_BUSY;
        end
      end
      omwq_pkg::CMD_UNLOCK: begin
        if (!locked_q || owner_q != tid_q) begin
          status_d = omwq_pkg::ST_NOT_OWNER;
        end else if (count_q != '0) begin
          // hand off to the head waiter
          head_d     = head_q + omwq_pkg::ptr_t'(1);
          count_d    = count_q - omwq_pkg::count_t'(1);
          owner_d    = wait_mem[head_q];
          wake_d     = 1'b1;
          wake_tid_d = wait_mem[head_q];
        end else begin
          locked_d = 1'b0;
          owner_d  = '0;
        end
      end
      omwq_pkg::CMD_DESTROY: begin
        if (locked_q || count_q != '0) begin
          status_d = omwq_pkg::ST_BUSY;
        end
      end
      omwq_pkg::CMD_INIT: begin
        locked_d = 1'b0;
        owner_d  = '0;
        head_d   = '0;
        tail_d   = '0;
        count_d  = '0;
      end
      default: begin
        // unused codes leave the state alone
      end
    endcase
  end

  // Update the mutex state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= 1'b0;
      owner_q  <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
    end else if (advance) begin
      locked_q <= locked_d;
      owner_q  <= owner_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
    end
  end

  // Append the caller at the queue tail
  always_ff @(posedge clk_i) begin
    if (advance && push) begin
      wait_mem[tail_q] <= tid_q;
    end
  end

  // Load the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q    <= status_d;
      wake_q      <= wake_d;
      wake_tid_q  <= wake_tid_d;
      held_q      <= locked_d;
      holder_q    <= locked_d ? owner_d : '0;
      count_out_q <= count_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = status_q;
  assign wake_valid_o   = wake_q;
  assign wake_thread_o  = wake_tid_q;
  assign held_o         = held_q;
  assign holder_o       = holder_q;
  assign waiter_count_o = count_out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Waiter count never passes the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= omwq_pkg::QueueFull)
    else $error("waiter count exceeds queue depth");

  // Pointer distance matches the waiter count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    omwq_pkg::ptr_t'(tail_q - head_q) == count_q[omwq_pkg::PtrW-1:0])
    else $error("queue pointers disagree with waiter count");

  // Waiters exist only while the mutex is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> locked_q)
    else $error("waiters queued on a free mutex");

  // A handoff leaves the mutex held by the woken thread
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wake_valid_o |-> held_o && holder_o == wake_thread_o)
    else $error("woken thread is not the holder");

endmodule

`default_nettype wire
